// File: rtl/dns_query_encoder_top_macros.svh
// Assertion macros shared by the dns query encoder RTL.
`ifndef DNS_QUERY_ENCODER_TOP_MACROS_SVH
`define DNS_QUERY_ENCODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk, off while arst_n is low
`define DQE_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dqe: same-cycle check failed");
// next-cycle implication, checked on clk, off while arst_n is low
`define DQE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dqe: next-cycle check failed");
`else
`define DQE_ASSERT_IMPL(name, ante, cons)
`define DQE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/dqe_pkg.sv
// Types and constants of the dns query encoder.
package dqe_pkg;
	localparam int MAX_LABEL_DEF = 63;
	localparam int MAX_NAME_DEF = 253;
	localparam int HDR_BYTES = 12;
	localparam int TRAIL_BYTES = 5;
	localparam int LCNT_W = 6;
	localparam int POS_W = 9;
	localparam int WLEN_W = 7;
	localparam int PAIR_W = 6;

	localparam logic [15:0] HDR_FLAGS = 16'h0100;
	localparam logic [15:0] QDCOUNT = 16'h0001;
	localparam logic [15:0] QCLASS_IN = 16'h0001;
	localparam logic [7:0] DOT_CHAR = 8'd46;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_CHAR = 2'd1,
		CMD_END = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_NAME = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [15:0] query_id;
		logic [15:0] query_type;
		logic [7:0] name_char;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic pair_valid;
		logic encode_error;
		logic run_last;
	} result_t;

	// everything the output stage needs to build one pair
	typedef struct packed {
		kind_t kind;
		logic [PAIR_W-1:0] idx;
		logic [WLEN_W-1:0] nl;
		logic [WLEN_W-1:0] wlen;
		logic [LCNT_W-1:0] len;
		logic [15:0] val;
		logic last;
	} pair_meta_t;

	typedef struct packed {
		logic valid;
		pair_meta_t meta;
	} pair_req_t;
endpackage

// File: rtl/dqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/dqe_seq.sv
// Command sequencer: query state, label writes and pair issue.
`include "dns_query_encoder_top_macros.svh"
module dqe_seq #(
	parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF,
	parameter int MAX_NAME = dqe_pkg::MAX_NAME_DEF,
	localparam int BANK_DEPTH = (MAX_LABEL + 1) / 2,
	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input dqe_pkg::item_t item,
	input logic issue_ok,
	output dqe_pkg::pair_req_t req,
	output logic we_even,
	output logic we_odd,
	output logic [AW-1:0] waddr,
	output logic [7:0] wdata,
	output logic re,
	output logic [AW-1:0] raddr_even,
	output logic [AW-1:0] raddr_odd
);
	localparam int LW = dqe_pkg::LCNT_W;
	localparam int PW = dqe_pkg::POS_W;
	localparam int WW = dqe_pkg::WLEN_W;
	localparam int KW = dqe_pkg::PAIR_W;

	dqe_pkg::state_t state_q, state_d;
	logic [LW-1:0] lcnt_q, lcnt_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0] type_q, type_d;
	logic open_q, open_d;
	logic [KW-1:0] idx_q, idx_d;

	dqe_pkg::kind_t em_kind_q, em_kind_d;
	logic [WW-1:0] em_nl_q, em_nl_d;
	logic [WW-1:0] em_wlen_q, em_wlen_d;
	logic [LW-1:0] em_len_q, em_len_d;
	logic [15:0] em_val_q, em_val_d;

	logic accept, fire, is_dot, over, full, go_err, em_load, wr_char;
	logic [WW-1:0] lbl_nl, npairs;

	assign item_ready = (state_q == dqe_pkg::ST_IDLE);
	assign accept = item_valid && item_ready;
	assign is_dot = (item.name_char == dqe_pkg::DOT_CHAR);
	assign lbl_nl = WW'(lcnt_q) + WW'(1);
	// pos + 1 + len + 1 + 4 against header + name + 6
	assign over = ({1'b0, pos_q} + (PW + 1)'(lcnt_q)) > (PW + 1)'(dqe_pkg::HDR_BYTES + MAX_NAME);
	assign full = (lcnt_q >= LW'(MAX_LABEL));
	assign npairs = (em_wlen_q + WW'(1)) >> 1;

	assign req.valid = (state_q == dqe_pkg::ST_EMIT);
	assign req.meta.kind = em_kind_q;
	assign req.meta.idx = idx_q;
	assign req.meta.nl = em_nl_q;
	assign req.meta.wlen = em_wlen_q;
	assign req.meta.len = em_len_q;
	assign req.meta.val = em_val_q;
	assign req.meta.last = (WW'(idx_q) == npairs - WW'(1));
	assign fire = req.valid && issue_ok;

	// label byte i lives in bank i[0] at i/2; pair k reads odd k-1 and even k
	assign re = fire;
	assign raddr_even = AW'(idx_q);
	assign raddr_odd = AW'(idx_q - KW'(1));
	assign waddr = AW'(lcnt_q >> 1);
	assign wdata = item.name_char;
	assign we_even = wr_char && !lcnt_q[0];
	assign we_odd = wr_char && lcnt_q[0];

	always_comb begin
		state_d = state_q;
		lcnt_d = lcnt_q;
		pos_d = pos_q;
		type_d = type_q;
		open_d = open_q;
		idx_d = idx_q;
		em_kind_d = em_kind_q;
		em_nl_d = em_nl_q;
		em_wlen_d = em_wlen_q;
		em_len_d = em_len_q;
		em_val_d = em_val_q;
		go_err = 1'b0;
		em_load = 1'b0;
		wr_char = 1'b0;
		case (state_q)
			dqe_pkg::ST_IDLE: begin
				idx_d = '0;
				if (accept) begin
					case (dqe_pkg::cmd_t'(item.cmd))
						dqe_pkg::CMD_START: begin
							em_load = 1'b1;
							em_kind_d = dqe_pkg::KIND_HDR;
							em_nl_d = '0;
							em_wlen_d = WW'(dqe_pkg::HDR_BYTES);
							em_val_d = item.query_id;
							type_d = item.query_type;
							pos_d = PW'(dqe_pkg::HDR_BYTES);
							lcnt_d = '0;
							open_d = 1'b1;
						end
						dqe_pkg::CMD_CHAR: begin
							if (open_q) begin
								if (is_dot) begin
									if (lcnt_q == '0 || over) begin
										go_err = 1'b1;
									end else begin
										em_load = 1'b1;
										em_kind_d = dqe_pkg::KIND_NAME;
										em_nl_d = lbl_nl;
										em_wlen_d = lbl_nl;
										em_len_d = lcnt_q;
										pos_d = pos_q + PW'(lbl_nl);
										lcnt_d = '0;
									end
								end else if (full) begin
									go_err = 1'b1;
								end else begin
									wr_char = 1'b1;
									lcnt_d = lcnt_q + LW'(1);
								end
							end
						end
						dqe_pkg::CMD_END: begin
							if (open_q) begin
								if (lcnt_q != '0 && over) begin
									go_err = 1'b1;
								end else begin
									em_load = 1'b1;
									em_kind_d = dqe_pkg::KIND_NAME;
									em_nl_d = (lcnt_q == '0) ? '0 : lbl_nl;
									em_wlen_d = em_nl_d + WW'(dqe_pkg::TRAIL_BYTES);
									em_len_d = lcnt_q;
									em_val_d = type_q;
									pos_d = pos_q + PW'(em_nl_d) + PW'(dqe_pkg::TRAIL_BYTES);
									lcnt_d = '0;
									open_d = 1'b0;
								end
							end
						end
						default: begin
						end
					endcase
					if (go_err) begin
						em_load = 1'b1;
						em_kind_d = dqe_pkg::KIND_ERR;
						em_nl_d = '0;
						em_wlen_d = WW'(1);
						lcnt_d = '0;
						open_d = 1'b0;
					end
					if (em_load) begin
						state_d = dqe_pkg::ST_EMIT;
					end
				end
			end
			dqe_pkg::ST_EMIT: begin
				if (fire) begin
					idx_d = idx_q + KW'(1);
					if (req.meta.last) begin
						state_d = dqe_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dqe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			pos_q <= '0;
			type_q <= '0;
			open_q <= 1'b0;
			idx_q <= '0;
		end else begin
			lcnt_q <= lcnt_d;
			pos_q <= pos_d;
			type_q <= type_d;
			open_q <= open_d;
			idx_q <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (em_load) begin
			em_kind_q <= em_kind_d;
			em_nl_q <= em_nl_d;
			em_wlen_q <= em_wlen_d;
			em_len_q <= em_len_d;
			em_val_q <= em_val_d;
		end
	end

	`DQE_ASSERT_NEXT(a_last_pair_idles, fire && req.meta.last, state_q == dqe_pkg::ST_IDLE)
	`DQE_ASSERT_IMPL(a_idx_in_range, state_q == dqe_pkg::ST_EMIT, WW'(idx_q) < npairs)
	`DQE_ASSERT_IMPL(a_no_write_in_emit, we_even || we_odd, state_q == dqe_pkg::ST_IDLE)
endmodule

// File: rtl/dqe_pack.sv
// Pair assembly from label RAM data, and the output register.
`include "dns_query_encoder_top_macros.svh"
module dqe_pack (
	input logic clk,
	input logic arst_n,
	input dqe_pkg::pair_req_t req,
	output logic issue_ok,
	input logic [7:0] rd_even,
	input logic [7:0] rd_odd,
	output logic result_valid,
	input logic result_ready,
	output dqe_pkg::result_t result
);
	localparam int WW = dqe_pkg::WLEN_W;

	logic valid_s1;
	dqe_pkg::pair_meta_t meta_s1;
	logic out_valid_q;
	dqe_pkg::result_t out_q, res_d;
	logic advance, pair;
	logic [WW-1:0] p0, p1;

	function automatic logic [7:0] wire_byte(dqe_pkg::pair_meta_t m, logic [WW-1:0] p,
		logic [7:0] lbl);
		logic [WW-1:0] t;
		logic [7:0] b;
		t = p - m.nl;
		b = '0;
		if (m.kind == dqe_pkg::KIND_HDR) begin
			case (p)
				7'd0: b = m.val[15:8];
				7'd1: b = m.val[7:0];
				7'd2: b = dqe_pkg::HDR_FLAGS[15:8];
				7'd3: b = dqe_pkg::HDR_FLAGS[7:0];
				7'd4: b = dqe_pkg::QDCOUNT[15:8];
				7'd5: b = dqe_pkg::QDCOUNT[7:0];
				default: b = '0;
			endcase
		end else if (p < m.nl) begin
			b = (p == '0) ? 8'(m.len) : lbl;
		end else begin
			// terminator, type, class
			case (t)
				7'd1: b = m.val[15:8];
				7'd2: b = m.val[7:0];
				7'd3: b = dqe_pkg::QCLASS_IN[15:8];
				7'd4: b = dqe_pkg::QCLASS_IN[7:0];
				default: b = '0;
			endcase
		end
		return b;
	endfunction

	assign advance = valid_s1 && (!out_valid_q || result_ready);
	assign issue_ok = !valid_s1 || advance;

	assign p0 = {meta_s1.idx, 1'b0};
	assign p1 = {meta_s1.idx, 1'b1};
	assign pair = (p1 < meta_s1.wlen);

	always_comb begin
		if (meta_s1.kind == dqe_pkg::KIND_ERR) begin
			res_d.byte_first = '0;
			res_d.byte_second = '0;
			res_d.pair_valid = 1'b0;
			res_d.encode_error = 1'b1;
			res_d.run_last = 1'b1;
		end else begin
			// first byte's label index is odd, second's even
			res_d.byte_first = wire_byte(meta_s1, p0, rd_odd);
			res_d.byte_second = pair ? wire_byte(meta_s1, p1, rd_even) : '0;
			res_d.pair_valid = pair;
			res_d.encode_error = 1'b0;
			res_d.run_last = meta_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_ok) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && issue_ok) begin
			meta_s1 <= req.meta;
		end
		if (advance) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	`DQE_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(meta_s1))
	`DQE_ASSERT_IMPL(a_err_alone, result_valid && result.encode_error, result.run_last && !result.pair_valid && result.byte_first == 8'd0)
	`DQE_ASSERT_IMPL(a_odd_tail_last, result_valid && !result.pair_valid, result.run_last)
endmodule

// File: rtl/dns_query_encoder_top.sv
// Top level of the dns query encoder.
// Builds a one-question DNS query from a word stream of start, name character
// and end items; wire bytes come out two per result word. A name character is
// taken and written into the label store, which is two RAM banks (even and odd
// label bytes, one read port each) so that one pair is read per cycle while the
// output side does not stall. An item that produces result words holds
// item_ready low after it is accepted until its last pair is issued, and longer
// while the result side stalls. The last two result words of an item may still
// sit in the read stage and the output register while the next item is taken.
// The label store needs no clearing after reset.
module dns_query_encoder_top #(
	parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF,
	parameter int MAX_NAME = dqe_pkg::MAX_NAME_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input dqe_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output dqe_pkg::result_t result
);
	localparam int BANK_DEPTH = (MAX_LABEL + 1) / 2;
	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	dqe_pkg::pair_req_t req;
	logic issue_ok;
	logic we_even, we_odd, re;
	logic [AW-1:0] waddr, raddr_even, raddr_odd;
	logic [7:0] wdata, rd_even, rd_odd;

	dqe_seq #(
		.MAX_LABEL(MAX_LABEL),
		.MAX_NAME(MAX_NAME)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.issue_ok(issue_ok),
		.req(req),
		.we_even(we_even),
		.we_odd(we_odd),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr_even(raddr_even),
		.raddr_odd(raddr_odd)
	);

	dqe_ram #(
		.WIDTH(8),
		.DEPTH(BANK_DEPTH)
	) u_ram_even (
		.clk(clk),
		.we(we_even),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr_even),
		.rdata(rd_even)
	);

	dqe_ram #(
		.WIDTH(8),
		.DEPTH(BANK_DEPTH)
	) u_ram_odd (
		.clk(clk),
		.we(we_odd),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr_odd),
		.rdata(rd_odd)
	);

	dqe_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.issue_ok(issue_ok),
		.rd_even(rd_even),
		.rd_odd(rd_odd),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);
endmodule
